>>> rtl/fifo_queue_with_reversal_unit_defines.svh
// assertion macros for the fifo queue with reversal unit
`ifndef FIFO_QUEUE_WITH_REVERSAL_UNIT_DEFINES_SVH
`define FIFO_QUEUE_WITH_REVERSAL_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FQR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fifo queue with reversal unit check failed");

// next-cycle implication, checked outside reset
`define FQR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fifo queue with reversal unit check failed");

`endif

>>> rtl/fqr_pkg.sv
// shared constants and types of the fifo queue with reversal unit
`timescale 1ns / 1ps

package fqr_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int ACT_W = 3;
    localparam int VAL_W = 32;
    localparam int IDX_W = 5;
    localparam int ST_W  = 2;
    localparam int OCC_W = 5;

    localparam int IN_TDATA_W  = ((VAL_W + IDX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + OCC_W + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - VAL_W - IDX_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - OCC_W;

    localparam logic [ACT_W-1:0] ACT_ENQ  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REVA = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REVK = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_BOUNDS    = 2'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd3;

    typedef enum logic [3:0] {
        FSM_IDLE = 4'b0001,
        FSM_READ = 4'b0010,
        FSM_SWA  = 4'b0100,
        FSM_SWB  = 4'b1000
    } fsm_t;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] value_in;
        logic [IDX_W-1:0]        index_or_count;
    } fqr_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic [ST_W-1:0]         status;
        logic [OCC_W-1:0]        occupancy;
    } fqr_res_t;

endpackage

>>> rtl/fifo_queue_with_reversal_unit.sv
// top level of the fifo queue with reversal unit: stream ports and result register
//
//  channel   dir  tdata (low bit up)                tuser
//  s_axis    in   value_in[31:0], index_or_count    action[2:0]
//  m_axis    out  value_out[31:0], occupancy        status[1:0]
//
//  enqueue, reverse all, and any error answer from idle; dequeue and peek pass through
//  one memory read; reverse first k swaps floor(min(k, occupancy) / 2) pairs in the swap
//  loop, each pair read, then written in states SWA and SWB on the single memory write port
//  the next command is taken once the sequencer is idle and the result register is free
//  rst_n clears pointers, occupancy and direction; the entry store is not cleared
`timescale 1ns / 1ps

module fifo_queue_with_reversal_unit #(
    parameter int QUEUE_DEPTH = fqr_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fqr_pkg::IN_TDATA_W-1:0]    s_tdata,   // value_in, index_or_count
    input  logic [fqr_pkg::ACT_W-1:0]         s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fqr_pkg::OUT_TDATA_W-1:0]   m_tdata,   // value_out, occupancy
    output logic [fqr_pkg::ST_W-1:0]          m_tuser    // status
);
    import fqr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    fqr_cmd_t                cmd;
    fqr_res_t                res;
    fqr_res_t                out_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_free;
    logic                    idle;
    logic                    accept;
    logic                    res_valid;
    logic                    we;
    logic                    re;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr_a;
    logic [AW-1:0]           raddr_b;
    logic signed [VAL_W-1:0] wdata;
    logic signed [VAL_W-1:0] rdata_a;
    logic signed [VAL_W-1:0] rdata_b;

    assign cmd.action         = s_tuser;
    assign cmd.value_in       = s_tdata[VAL_W-1:0];
    assign cmd.index_or_count = s_tdata[VAL_W+IDX_W-1:VAL_W];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = idle && out_free;
    assign accept   = s_tvalid && s_tready;

    fqr_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_accept (accept),
        .cmd        (cmd),
        .idle       (idle),
        .res_valid  (res_valid),
        .res        (res),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .re         (re),
        .raddr_a    (raddr_a),
        .raddr_b    (raddr_b),
        .rdata_a    (rdata_a),
        .rdata_b    (rdata_b)
    );

    fqr_ram #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // a result only arrives for the command taken while the register was free
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.occupancy, out_reg.value_out};
    assign m_tuser  = out_reg.status;

endmodule

>>> rtl/fqr_ram.sv
// entry store: one write port, two registered read ports
`timescale 1ns / 1ps

module fqr_ram #(
    parameter int QUEUE_DEPTH = fqr_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]       waddr,
    input  logic signed [fqr_pkg::VAL_W-1:0]     wdata,
    input  logic                                 re,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]       raddr_a,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]       raddr_b,
    output logic signed [fqr_pkg::VAL_W-1:0]     rdata_a,
    output logic signed [fqr_pkg::VAL_W-1:0]     rdata_b
);
    import fqr_pkg::*;

    logic signed [VAL_W-1:0] mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> rtl/fqr_ctrl.sv
// command sequencer: ring pointers, occupancy, direction flag and swap loop
`timescale 1ns / 1ps

module fqr_ctrl #(
    parameter int QUEUE_DEPTH = fqr_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_accept,
    input  fqr_pkg::fqr_cmd_t                    cmd,
    output logic                                 idle,
    output logic                                 res_valid,
    output fqr_pkg::fqr_res_t                    res,
    output logic                                 we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]       waddr,
    output logic signed [fqr_pkg::VAL_W-1:0]     wdata,
    output logic                                 re,
    output logic [$clog2(QUEUE_DEPTH)-1:0]       raddr_a,
    output logic [$clog2(QUEUE_DEPTH)-1:0]       raddr_b,
    input  logic signed [fqr_pkg::VAL_W-1:0]     rdata_a,
    input  logic signed [fqr_pkg::VAL_W-1:0]     rdata_b
);
    import fqr_pkg::*;

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int XW0 = (CW > IDX_W) ? CW : IDX_W;
    localparam int XW  = (XW0 > OCC_W) ? XW0 : OCC_W;
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    fsm_t            state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            rev_reg, rev_next;
    logic [AW-1:0]   lo_reg, lo_next;
    logic [AW-1:0]   hi_reg, hi_next;
    logic [AW-1:0]   slot_a_reg, slot_a_next;
    logic [AW-1:0]   slot_b_reg, slot_b_next;

    logic [XW-1:0]   idx_x;
    logic [XW-1:0]   cnt_x;
    logic [XW-1:0]   occ_x;
    logic [CW-1:0]   k_cnt;
    logic [CW-1:0]   k_dec;
    logic [AW-1:0]   lo_inc;
    logic [AW-1:0]   hi_dec;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    // ring slot of a logical position from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head, input logic [CW-1:0] cnt,
                                              input logic rev, input logic [AW-1:0] pos);
        logic [CW-1:0] off_c;
        logic [AW-1:0] off;
        off_c = cnt - CW'(1) - CW'(pos);
        off   = rev ? off_c[AW-1:0] : pos;
        return wrap_add(head, off);
    endfunction

    assign idle   = (state_reg == FSM_IDLE);
    assign idx_x  = XW'(cmd.index_or_count);
    assign cnt_x  = XW'(count_reg);
    assign k_cnt  = (idx_x < cnt_x) ? idx_x[CW-1:0] : count_reg;
    assign k_dec  = k_cnt - CW'(1);
    assign lo_inc = lo_reg + AW'(1);
    assign hi_dec = hi_reg - AW'(1);
    assign occ_x  = XW'(count_next);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        slot_a_next = slot_a_reg;
        slot_b_next = slot_b_reg;
        we          = 1'b0;
        waddr       = slot_a_reg;
        wdata       = rdata_b;
        re          = 1'b0;
        raddr_a     = slot_a_reg;
        raddr_b     = slot_b_reg;
        res_valid   = 1'b0;
        res.value_out = '0;
        res.status    = ST_OK;

        case (state_reg)
            FSM_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.action)
                        ACT_ENQ:
                        begin
                            res_valid = 1'b1;
                            if (count_reg == DEPTH_C)
                            begin
                                res.value_out = '1;
                                res.status    = ST_OVERFLOW;
                            end
                            else
                            begin
                                we    = 1'b1;
                                wdata = cmd.value_in;
                                if (rev_reg)
                                begin
                                    head_next = (head_reg == '0) ? LAST_SLOT
                                                                 : head_reg - AW'(1);
                                    waddr     = head_next;
                                end
                                else
                                begin
                                    waddr = wrap_add(head_reg, count_reg[AW-1:0]);
                                end
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid     = 1'b1;
                                res.value_out = '1;
                                res.status    = ST_UNDERFLOW;
                            end
                            else
                            begin
                                re      = 1'b1;
                                raddr_a = slot_of(head_reg, count_reg, rev_reg, '0);
                                if (!rev_reg)
                                begin
                                    head_next = (head_reg == LAST_SLOT) ? '0
                                                                        : head_reg + AW'(1);
                                end
                                count_next = count_reg - CW'(1);
                                state_next = FSM_READ;
                            end
                        end
                        ACT_PEEK:
                        begin
                            if (idx_x >= cnt_x)
                            begin
                                res_valid     = 1'b1;
                                res.value_out = '1;
                                res.status    = ST_BOUNDS;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr_a    = slot_of(head_reg, count_reg, rev_reg,
                                                     idx_x[AW-1:0]);
                                state_next = FSM_READ;
                            end
                        end
                        ACT_REVA:
                        begin
                            res_valid = 1'b1;
                            rev_next  = !rev_reg;
                        end
                        ACT_REVK:
                        begin
                            if (k_cnt < CW'(2))
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                re          = 1'b1;
                                slot_a_next = slot_of(head_reg, count_reg, rev_reg, '0);
                                slot_b_next = slot_of(head_reg, count_reg, rev_reg,
                                                      k_dec[AW-1:0]);
                                raddr_a     = slot_a_next;
                                raddr_b     = slot_b_next;
                                lo_next     = '0;
                                hi_next     = k_dec[AW-1:0];
                                state_next  = FSM_SWA;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            FSM_READ:
            begin
                res_valid     = 1'b1;
                res.value_out = rdata_a;
                state_next    = FSM_IDLE;
            end
            FSM_SWA:
            begin
                we         = 1'b1;
                waddr      = slot_a_reg;
                wdata      = rdata_b;
                state_next = FSM_SWB;
            end
            FSM_SWB:
            begin
                we    = 1'b1;
                waddr = slot_b_reg;
                wdata = rdata_a;
                // next pair is disjoint from the slot written here
                if (lo_inc < hi_dec)
                begin
                    re          = 1'b1;
                    lo_next     = lo_inc;
                    hi_next     = hi_dec;
                    slot_a_next = slot_of(head_reg, count_reg, rev_reg, lo_inc);
                    slot_b_next = slot_of(head_reg, count_reg, rev_reg, hi_dec);
                    raddr_a     = slot_a_next;
                    raddr_b     = slot_b_next;
                    state_next  = FSM_SWA;
                end
                else
                begin
                    res_valid  = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        res.occupancy = occ_x[OCC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        slot_a_reg <= slot_a_next;
        slot_b_reg <= slot_b_next;
    end

endmodule

>>> rtl/fqr_checker.sv
// port checker for the fifo queue with reversal unit, bound to the top level
`timescale 1ns / 1ps
`include "fifo_queue_with_reversal_unit_defines.svh"

module fqr_checker #(
    parameter int QUEUE_DEPTH = fqr_pkg::DEPTH_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [fqr_pkg::IN_TDATA_W-1:0]    s_tdata,
    input logic [fqr_pkg::ACT_W-1:0]         s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fqr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic [fqr_pkg::ST_W-1:0]          m_tuser
);
    import fqr_pkg::*;

    logic [OCC_W-1:0] occ;
    logic [VAL_W-1:0] val;
    logic             in_xfer;

    assign occ     = m_tdata[VAL_W+OCC_W-1:VAL_W];
    assign val     = m_tdata[VAL_W-1:0];
    assign in_xfer = s_tvalid && s_tready && (s_tdata != '1 || s_tuser != '1);

    `FQR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `FQR_ASSERT_IMP(a_no_take_when_stalled, m_tvalid && !m_tready, !s_tready && !in_xfer)
    `FQR_ASSERT_IMP(a_error_value, m_tvalid && m_tuser != ST_OK, val == '1)
    `FQR_ASSERT_IMP(a_underflow_empty, m_tvalid && m_tuser == ST_UNDERFLOW, occ == '0)
    `FQR_ASSERT_IMP(a_overflow_full, m_tvalid && m_tuser == ST_OVERFLOW, occ == OCC_W'(QUEUE_DEPTH))

endmodule

bind fifo_queue_with_reversal_unit fqr_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_fqr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/fifo_queue_with_reversal_unit_checker.sv
// checker for the fifo queue with reversal unit: predicts each result and compares transfers
`timescale 1ns / 1ps

module fifo_queue_with_reversal_unit_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [fqr_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [fqr_pkg::ACT_W-1:0]         s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [fqr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic [fqr_pkg::ST_W-1:0]          m_tuser,
    output int                                errors,
    output int                                pending,
    output int                                checked,
    output int                                overflows,
    output int                                underflows,
    output int                                out_of_bounds,
    output int                                partial_flips
);
    import fqr_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    logic signed [VAL_W-1:0] slots [DEPTH];
    int       front;
    int       fill;
    bit       flipped;
    fqr_res_t queue_replies [$];

    function automatic int slot_at(input int pos);
        if (flipped)
        begin
            return (front + fill + DEPTH - 1 - pos) % DEPTH;
        end
        return (front + pos) % DEPTH;
    endfunction

    task automatic predict_reply(input fqr_cmd_t cmd, output fqr_res_t rep);
        int                      k;
        int                      lo;
        int                      a;
        int                      b;
        logic signed [VAL_W-1:0] t;
        rep.value_out = '0;
        rep.status    = ST_OK;
        case (cmd.action)
            ACT_ENQ:
            begin
                if (fill >= DEPTH)
                begin
                    rep.value_out = -1;
                    rep.status    = ST_OVERFLOW;
                    overflows++;
                end
                else if (flipped)
                begin
                    front        = (front + DEPTH - 1) % DEPTH;
                    slots[front] = cmd.value_in;
                    fill++;
                end
                else
                begin
                    slots[(front + fill) % DEPTH] = cmd.value_in;
                    fill++;
                end
            end
            ACT_DEQ:
            begin
                if (fill == 0)
                begin
                    rep.value_out = -1;
                    rep.status    = ST_UNDERFLOW;
                    underflows++;
                end
                else
                begin
                    rep.value_out = slots[slot_at(0)];
                    if (!flipped)
                    begin
                        front = (front + 1) % DEPTH;
                    end
                    fill--;
                end
            end
            ACT_PEEK:
            begin
                if (int'(cmd.index_or_count) >= fill)
                begin
                    rep.value_out = -1;
                    rep.status    = ST_BOUNDS;
                    out_of_bounds++;
                end
                else
                begin
                    rep.value_out = slots[slot_at(int'(cmd.index_or_count))];
                end
            end
            ACT_REVA:
            begin
                flipped = !flipped;
            end
            ACT_REVK:
            begin
                k = (int'(cmd.index_or_count) < fill) ? int'(cmd.index_or_count) : fill;
                if (k >= 2)
                begin
                    partial_flips++;
                end
                for (lo = 0; k >= 2 && lo < k - 1 - lo; lo++)
                begin
                    a        = slot_at(lo);
                    b        = slot_at(k - 1 - lo);
                    t        = slots[a];
                    slots[a] = slots[b];
                    slots[b] = t;
                end
            end
            default:
            begin
            end
        endcase
        rep.occupancy = fill[OCC_W-1:0];
    endtask

    task automatic report_bad(input fqr_res_t want, input fqr_res_t got, input bit orphan);
        errors++;
        if (errors <= 10)
        begin
            if (orphan)
            begin
                $display("%0t: result transfer with nothing expected: value %0d status %0d occupancy %0d",
                         $realtime, got.value_out, got.status, got.occupancy);
            end
            else
            begin
                $display("%0t: mismatch: expected value %0d status %0d occupancy %0d",
                         $realtime, want.value_out, want.status, want.occupancy);
                $display("%0t:           got      value %0d status %0d occupancy %0d",
                         $realtime, got.value_out, got.status, got.occupancy);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        fqr_cmd_t cmd;
        fqr_res_t want;
        fqr_res_t got;
        if (!rst_n)
        begin
            front         = 0;
            fill          = 0;
            flipped       = 1'b0;
            errors        = 0;
            checked       = 0;
            overflows     = 0;
            underflows    = 0;
            out_of_bounds = 0;
            partial_flips = 0;
            queue_replies.delete();
            pending       = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cmd.action         = s_tuser;
                cmd.value_in       = s_tdata[VAL_W-1:0];
                cmd.index_or_count = s_tdata[VAL_W +: IDX_W];
                predict_reply(cmd, want);
                queue_replies.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.value_out = m_tdata[VAL_W-1:0];
                got.occupancy = m_tdata[VAL_W +: OCC_W];
                got.status    = m_tuser;
                checked++;
                if (queue_replies.size() == 0)
                begin
                    report_bad(got, got, 1'b1);
                end
                else
                begin
                    want = queue_replies.pop_front();
                    if (got.value_out !== want.value_out || got.status !== want.status ||
                        got.occupancy !== want.occupancy)
                    begin
                        report_bad(want, got, 1'b0);
                    end
                end
            end
            pending = queue_replies.size();
        end
    end

endmodule

>>> dv/fifo_queue_with_reversal_unit_tb.sv
// testbench top for the fifo queue with reversal unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module fifo_queue_with_reversal_unit_tb;
    import fqr_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 15;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]        m_tuser;

    int errors;
    int pending;
    int checked;
    int overflows;
    int underflows;
    int out_of_bounds;
    int partial_flips;

    int sent;
    int work_items;
    int hold_ticket;
    bit calm;

    fifo_queue_with_reversal_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fifo_queue_with_reversal_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .overflows     (overflows),
        .underflows    (underflows),
        .out_of_bounds (out_of_bounds),
        .partial_flips (partial_flips)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin : receiver
        int served;
        int held;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != served)
            begin
                served = hold_ticket;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                            input logic [IDX_W-1:0] idx);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{IN_PAD_W{1'b0}}, idx, val};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sent++;
        if (act <= ACT_REVK)
        begin
            work_items++;
        end
    endtask

    task automatic drain_all();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic random_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            send_cmd(ACT_ENQ, rand_word(), IDX_W'($urandom_range(0, 16)));
        else if (r < 60)
            send_cmd(ACT_DEQ, rand_word(), IDX_W'($urandom_range(0, 16)));
        else if (r < 78)
            send_cmd(ACT_PEEK, rand_word(), IDX_W'($urandom_range(0, 16)));
        else if (r < 86)
            send_cmd(ACT_REVA, rand_word(), IDX_W'($urandom_range(0, 16)));
        else if (r < 98)
            send_cmd(ACT_REVK, rand_word(), IDX_W'($urandom_range(0, 16)));
        else
            send_cmd(ACT_W'($urandom_range(5, 7)), rand_word(), IDX_W'($urandom_range(0, 16)));
    endtask

    initial
    begin : stimulus
        int  n;
        int  i;
        bit  held_once;
        bit  paused_once;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_ENQ;
        m_tready    = 1'b0;
        calm        = 1'b0;
        hold_ticket = 0;
        sent        = 0;
        work_items  = 0;
        held_once   = 1'b0;
        paused_once = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corners
        send_cmd(ACT_DEQ, 32'h0, 5'd0);
        send_cmd(ACT_PEEK, 32'h0, 5'd0);
        send_cmd(ACT_REVK, 32'h0, 5'd16);
        send_cmd(ACT_REVA, 32'h0, 5'd0);
        send_cmd(ACT_REVA, 32'h0, 5'd0);
        // extreme words
        send_cmd(ACT_ENQ, 32'h7FFF_FFFF, 5'd0);
        send_cmd(ACT_ENQ, 32'h8000_0000, 5'd31);
        send_cmd(ACT_ENQ, 32'hFFFF_FFFF, 5'd0);
        send_cmd(ACT_ENQ, 32'h0000_0000, 5'd0);
        send_cmd(ACT_ENQ, 32'h1234_5678, 5'd0);
        send_cmd(ACT_PEEK, 32'h0, 5'd0);
        send_cmd(ACT_PEEK, 32'h0, 5'd4);
        send_cmd(ACT_PEEK, 32'h0, 5'd5);
        send_cmd(ACT_PEEK, 32'h0, 5'd16);
        // partial reversals, including k past the occupancy
        send_cmd(ACT_REVK, 32'h0, 5'd0);
        send_cmd(ACT_REVK, 32'h0, 5'd1);
        send_cmd(ACT_REVK, 32'h0, 5'd4);
        send_cmd(ACT_REVK, 32'h0, 5'd16);
        // enqueue and dequeue while reversed
        send_cmd(ACT_REVA, 32'h0, 5'd0);
        send_cmd(ACT_ENQ, 32'hA5A5_A5A5, 5'd0);
        send_cmd(ACT_DEQ, 32'h0, 5'd0);
        send_cmd(ACT_PEEK, 32'h0, 5'd1);
        // unused actions
        send_cmd(3'd5, 32'hDEAD_BEEF, 5'd3);
        send_cmd(3'd6, 32'hFFFF_FFFF, 5'd16);
        send_cmd(3'd7, 32'h5555_AAAA, 5'd9);
        drain_all();

        work_items = 0;
        while (work_items < RANDOM_ITEMS)
        begin
            calm <= (work_items >= 320 && work_items < 450);
            if (!held_once && work_items >= 200)
            begin
                hold_ticket <= hold_ticket + 1;
                held_once = 1'b1;
            end
            if (!paused_once && work_items >= 550)
            begin
                drain_all();
                paused_once = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    n = $urandom_range(4, 20);
                    for (i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            send_cmd(ACT_REVK, rand_word(), IDX_W'($urandom_range(2, 16)));
                        else
                            send_cmd(ACT_ENQ, rand_word(), 5'd0);
                    end
                end
                3, 4:
                begin
                    n = $urandom_range(3, 18);
                    for (i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 5) == 0)
                            send_cmd(ACT_PEEK, rand_word(), IDX_W'($urandom_range(0, 16)));
                        else
                            send_cmd(ACT_DEQ, rand_word(), IDX_W'($urandom_range(0, 16)));
                    end
                end
                5:
                begin
                    n = $urandom_range(1, 16);
                    for (i = 0; i <= n; i++)
                    begin
                        send_cmd(ACT_PEEK, rand_word(), IDX_W'(i));
                    end
                end
                6:
                begin
                    send_cmd(ACT_REVK, rand_word(), IDX_W'($urandom_range(0, 16)));
                    for (i = 0; i < 4; i++)
                    begin
                        send_cmd(ACT_PEEK, rand_word(), IDX_W'($urandom_range(0, 8)));
                    end
                end
                default:
                begin
                    n = $urandom_range(10, 30);
                    for (i = 0; i < n; i++)
                    begin
                        random_cmd();
                    end
                end
            endcase
        end

        drain_all();
        repeat (50) @(posedge clk);
        @(negedge clk);
        $display("queue run: %0d commands sent, %0d result transfers checked, %0d mismatches",
                 sent, checked, errors);
        $display("corners hit: %0d overflow, %0d underflow, %0d out of bounds, %0d partial reversals",
                 overflows, underflows, out_of_bounds, partial_flips);
        if (errors == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
